### rtl/core/pfs_pkg.sv
// Shared types and constants for the periodic frame scheduler.
// Used by pfs_cell, pfs_div and periodic_frame_scheduler_unit; no dependencies.
`default_nettype none

package pfs_pkg;

    // field widths
    localparam int OP_W        = 2;
    localparam int ID_W        = 11;
    localparam int LEN_W       = 4;
    localparam int RATE_W      = 8;
    localparam int OFF_W       = 3;
    localparam int WCNT_W      = 4;
    localparam int PAYLOAD_BYTES = 8;
    localparam int PAYLOAD_W   = 8 * PAYLOAD_BYTES;
    localparam int TIME_W      = 32;
    localparam int SLOT_W      = 3;
    localparam int INTERVAL_W  = 10;

    // table defaults and limits
    localparam int TABLE_ENTRIES_DEF = 8;
    localparam int MAX_RESULTS = 8;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    // interval = INTERVAL_BASE / rate
    localparam logic [INTERVAL_W-1:0] INTERVAL_BASE = 10'd1000;
    localparam int DIV_CNT_W   = $clog2(INTERVAL_W);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(PAYLOAD_BYTES);

    // operation codes
    localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE    = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK     = 2'd2;

    // result kinds and status
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_FRAME = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic                  bus;
        logic [ID_W-1:0]       ident;
        logic [LEN_W-1:0]      length;
        logic [INTERVAL_W-1:0] interval;
        logic [TIME_W-1:0]     last_sent;
        logic [PAYLOAD_W-1:0]  payload;
    } entry_t;

    typedef struct packed {
        logic                 kind;
        logic                 status;
        logic [SLOT_W-1:0]    slot;
        logic                 bus;
        logic [ID_W-1:0]      ident;
        logic [LEN_W-1:0]     length;
        logic [PAYLOAD_W-1:0] payload;
        logic                 last;
    } res_t;

endpackage

`default_nettype wire

### rtl/core/pfs_cell.sv
// One table cell of the rotating entry ring.
// Depends on pfs_pkg (entry_t).
`default_nettype none

module pfs_cell
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           shift_en,
    input  wire pfs_pkg::entry_t d,
    output pfs_pkg::entry_t     q
);

    logic                           bus_reg;
    logic [pfs_pkg::ID_W-1:0]       ident_reg;
    logic [pfs_pkg::LEN_W-1:0]      length_reg;
    logic [pfs_pkg::INTERVAL_W-1:0] interval_reg;
    logic [pfs_pkg::TIME_W-1:0]     last_sent_reg;
    logic [pfs_pkg::PAYLOAD_W-1:0]  payload_reg;

    // timestamp and payload start at zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sent_reg <= '0;
            payload_reg   <= '0;
        end
        else if (shift_en)
        begin
            last_sent_reg <= d.last_sent;
            payload_reg   <= d.payload;
        end
    end

    // key fields are written before first use
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            bus_reg      <= d.bus;
            ident_reg    <= d.ident;
            length_reg   <= d.length;
            interval_reg <= d.interval;
        end
    end

    assign q.bus       = bus_reg;
    assign q.ident     = ident_reg;
    assign q.length    = length_reg;
    assign q.interval  = interval_reg;
    assign q.last_sent = last_sent_reg;
    assign q.payload   = payload_reg;

endmodule

`default_nettype wire

### rtl/core/pfs_div.sv
// Bit-serial restoring divider: quotient = INTERVAL_BASE / rate (rate 0 taken as 1).
// Depends on pfs_pkg.
`default_nettype none

module pfs_div
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [pfs_pkg::RATE_W-1:0]       rate,
    output logic                                  done,
    output logic [pfs_pkg::INTERVAL_W-1:0]        quotient
);

    localparam logic [pfs_pkg::DIV_CNT_W-1:0] LAST_BIT =
        pfs_pkg::DIV_CNT_W'(pfs_pkg::INTERVAL_W - 1);

    logic                               busy_reg;
    logic                               done_reg;
    logic [pfs_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic [pfs_pkg::RATE_W-1:0]         den_reg;
    logic [pfs_pkg::RATE_W-1:0]         rem_reg;
    logic [pfs_pkg::INTERVAL_W-1:0]     quo_reg;

    logic [pfs_pkg::DIV_CNT_W-1:0]      bit_idx;
    logic [pfs_pkg::RATE_W:0]           trial;
    logic                               ge;

    always_comb
    begin
        bit_idx = LAST_BIT - cnt_reg;
        trial   = {rem_reg, pfs_pkg::INTERVAL_BASE[bit_idx]};
        ge      = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST_BIT)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= (rate == '0) ? pfs_pkg::RATE_W'(1) : rate;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? pfs_pkg::RATE_W'(trial - {1'b0, den_reg})
                          : pfs_pkg::RATE_W'(trial);
            quo_reg <= {quo_reg[pfs_pkg::INTERVAL_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### rtl/core/periodic_frame_scheduler_unit.sv
// Top level of the periodic frame scheduler: command sequencer, head-of-ring logic,
// result staging. Depends on pfs_pkg, pfs_cell, pfs_div.
`default_nettype none

// Channel  Dir  tdata (low bit up)                                tuser        tlast
// s_*      in   bus_sel, frame_id, frame_length, rate_hz,          op           -
//               write_offset, write_count, write_data, now_ms, pad
// m_*      out  status, slot_index, out_bus, out_id, out_length,   result_kind  last_result
//               out_payload, pad
//
// The table is a ring of TABLE_ENTRIES cells that rotates by one cell per step; the
// head cell is checked and updated on its way back to the tail, so one item takes
// one full rotation, which for a register item follows the serial interval divide.
// Rotation pauses while a due frame waits for the result register to drain.
// Reset clears the entry count and the cell timestamps and payloads; no clearing pass.
// s_tready is high only while no item is in work.

module periodic_frame_scheduler_unit
#(
    parameter int TABLE_ENTRIES = pfs_pkg::TABLE_ENTRIES_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // bus_sel[0], frame_id[11:1], frame_length[15:12], rate_hz[23:16],
    // write_offset[26:24], write_count[30:27], write_data[94:31], now_ms[126:95]
    input  wire logic [127:0]  s_tdata,
    // op
    input  wire logic [1:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // status[0], slot_index[3:1], out_bus[4], out_id[15:5], out_length[19:16],
    // out_payload[83:20]
    output logic [87:0]        m_tdata,
    // result_kind
    output logic               m_tuser,
    // last_result
    output logic               m_tlast
);

    localparam int STEP_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t                          state_reg;
    logic [STEP_W-1:0]               step_reg;
    logic [CNT_W-1:0]                count_reg;
    logic [pfs_pkg::NRES_W-1:0]      nres_reg;
    logic                            found_reg;
    logic [STEP_W-1:0]               found_slot_reg;
    logic                            appended_reg;
    logic                            hold_valid_reg;
    logic                            m_valid_reg;

    // latched command
    logic [pfs_pkg::OP_W-1:0]        op_reg;
    logic                            bus_reg;
    logic [pfs_pkg::ID_W-1:0]        id_reg;
    logic [pfs_pkg::LEN_W-1:0]       len_reg;
    logic [pfs_pkg::OFF_W-1:0]       off_reg;
    logic [pfs_pkg::WCNT_W-1:0]      wcnt_reg;
    logic [pfs_pkg::PAYLOAD_W-1:0]   data_reg;
    logic [pfs_pkg::TIME_W-1:0]      now_reg;
    logic [pfs_pkg::INTERVAL_W-1:0]  interval_reg;

    pfs_pkg::res_t                   hold_reg;
    pfs_pkg::res_t                   m_res_reg;

    pfs_pkg::entry_t                 cell_q [TABLE_ENTRIES];
    pfs_pkg::entry_t                 head;
    pfs_pkg::entry_t                 head_next;

    logic                            div_done;
    logic [pfs_pkg::INTERVAL_W-1:0]  div_quotient;

    logic                            load_cmd;
    logic [CNT_W-1:0]                step_ext;
    logic                            slot_valid;
    logic                            key_match;
    logic                            append_now;
    logic [pfs_pkg::TIME_W-1:0]      elapsed;
    logic                            due;
    logic                            out_free;
    logic                            stall;
    logic                            advance;
    logic                            last_step;
    logic                            hold_load_frame;
    logic                            hold_load_reply;
    logic                            out_load_mid;
    logic                            out_load_final;
    logic [pfs_pkg::PAYLOAD_W-1:0]   merged_payload;
    logic [pfs_pkg::LEN_W-1:0]       len_sat;
    pfs_pkg::res_t                   frame_res;
    pfs_pkg::res_t                   reply_res;
    pfs_pkg::res_t                   out_res;

    //------------------------------------------------------------------
    // entry ring: cell i takes cell i+1, the tail takes the updated head
    //------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            pfs_pkg::entry_t cell_d;
            if (gi == TABLE_ENTRIES - 1)
            begin : g_tail
                assign cell_d = head_next;
            end
            else
            begin : g_body
                assign cell_d = cell_q[gi+1];
            end
            pfs_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (advance),
                .d        (cell_d),
                .q        (cell_q[gi])
            );
        end
    endgenerate

    assign head = cell_q[0];

    pfs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (load_cmd && s_tuser == pfs_pkg::OP_REGISTER),
        .rate     (s_tdata[23:16]),
        .done     (div_done),
        .quotient (div_quotient)
    );

    //------------------------------------------------------------------
    // head-of-ring evaluation
    //------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign load_cmd = s_tvalid && s_tready;

    always_comb
    begin
        step_ext   = CNT_W'(step_reg);
        slot_valid = step_ext < count_reg;
        key_match  = slot_valid && head.bus == bus_reg && head.ident == id_reg;
        // every valid slot has passed the head once the step reaches the count
        append_now = (op_reg == pfs_pkg::OP_REGISTER) && !found_reg
                     && step_ext == count_reg && count_reg < FULL_COUNT;
        elapsed    = now_reg - head.last_sent;
        due        = (op_reg == pfs_pkg::OP_TICK) && slot_valid
                     && nres_reg < pfs_pkg::NRES_W'(pfs_pkg::MAX_RESULTS)
                     && elapsed > pfs_pkg::TIME_W'(head.interval);
        out_free   = !m_valid_reg || m_tready;
        stall      = due && hold_valid_reg && !out_free;
        advance    = (state_reg == ST_SCAN) && !stall;
        last_step  = step_reg == LAST_STEP;
        len_sat    = (len_reg > pfs_pkg::MAX_LEN) ? pfs_pkg::MAX_LEN : len_reg;

        hold_load_frame = advance && due;
        hold_load_reply = advance && last_step && op_reg == pfs_pkg::OP_REGISTER;
        out_load_mid    = advance && due && hold_valid_reg;
        out_load_final  = (state_reg == ST_FLUSH) && hold_valid_reg && out_free;

        // only the flush of the held result closes the item
        out_res      = hold_reg;
        out_res.last = out_load_final;
    end

    // byte-wise payload merge, clipped at the last byte
    always_comb
    begin
        logic [pfs_pkg::OFF_W-1:0] rel;
        logic                      hit;
        merged_payload = head.payload;
        for (int p = 0; p < pfs_pkg::PAYLOAD_BYTES; p++)
        begin
            rel = pfs_pkg::OFF_W'(p) - off_reg;
            hit = (pfs_pkg::OFF_W'(p) >= off_reg) && ({1'b0, rel} < wcnt_reg);
            if (hit)
            begin
                merged_payload[8*p +: 8] = data_reg[{rel, 3'b000} +: 8];
            end
        end
    end

    always_comb
    begin
        head_next = head;
        if (append_now)
        begin
            head_next.bus      = bus_reg;
            head_next.ident    = id_reg;
            head_next.length   = len_sat;
            head_next.interval = interval_reg;
        end
        if (op_reg == pfs_pkg::OP_WRITE && key_match)
        begin
            head_next.payload = merged_payload;
        end
        if (due)
        begin
            head_next.last_sent = now_reg;
        end
    end

    always_comb
    begin
        frame_res         = '0;
        frame_res.kind    = pfs_pkg::KIND_FRAME;
        frame_res.status  = pfs_pkg::STATUS_OK;
        frame_res.slot    = pfs_pkg::SLOT_W'(step_reg);
        frame_res.bus     = head.bus;
        frame_res.ident   = head.ident;
        frame_res.length  = head.length;
        frame_res.payload = head.payload;

        reply_res         = '0;
        reply_res.kind    = pfs_pkg::KIND_REPLY;
        priority if (found_reg)
        begin
            reply_res.slot = pfs_pkg::SLOT_W'(found_slot_reg);
        end
        else if (key_match)
        begin
            reply_res.slot = pfs_pkg::SLOT_W'(step_reg);
        end
        else if (append_now || appended_reg)
        begin
            // new entry lands at the old count
            reply_res.slot = pfs_pkg::SLOT_W'(count_reg);
        end
        else
        begin
            reply_res.status = pfs_pkg::STATUS_FULL;
        end
    end

    //------------------------------------------------------------------
    // sequencer and control state
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            count_reg      <= '0;
            nres_reg       <= '0;
            found_reg      <= 1'b0;
            found_slot_reg <= '0;
            appended_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (out_load_mid || out_load_final)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (load_cmd)
                    begin
                        step_reg     <= '0;
                        nres_reg     <= '0;
                        found_reg    <= 1'b0;
                        appended_reg <= 1'b0;
                        state_reg    <= (s_tuser == pfs_pkg::OP_REGISTER) ? ST_DIV : ST_SCAN;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (advance)
                    begin
                        if (op_reg == pfs_pkg::OP_REGISTER && key_match)
                        begin
                            found_reg      <= 1'b1;
                            found_slot_reg <= step_reg;
                        end
                        if (append_now)
                        begin
                            appended_reg <= 1'b1;
                        end
                        if (due)
                        begin
                            hold_valid_reg <= 1'b1;
                            nres_reg       <= nres_reg + 1'b1;
                        end
                        if (last_step)
                        begin
                            step_reg  <= '0;
                            state_reg <= ST_FLUSH;
                            if (op_reg == pfs_pkg::OP_REGISTER)
                            begin
                                hold_valid_reg <= 1'b1;
                                if (append_now || appended_reg)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (!hold_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        hold_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    //------------------------------------------------------------------
    // command and result data registers
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load_cmd)
        begin
            op_reg   <= s_tuser;
            bus_reg  <= s_tdata[0];
            id_reg   <= s_tdata[11:1];
            len_reg  <= s_tdata[15:12];
            off_reg  <= s_tdata[26:24];
            wcnt_reg <= s_tdata[30:27];
            data_reg <= s_tdata[94:31];
            now_reg  <= s_tdata[126:95];
        end
        if (state_reg == ST_DIV && div_done)
        begin
            interval_reg <= div_quotient;
        end

        // a held result moves out when the next due frame is found, or in the flush
        if (out_load_mid || out_load_final)
        begin
            m_res_reg <= out_res;
        end

        if (hold_load_frame)
        begin
            hold_reg <= frame_res;
        end
        else if (hold_load_reply)
        begin
            hold_reg <= reply_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_res_reg.payload, m_res_reg.length, m_res_reg.ident,
                       m_res_reg.bus, m_res_reg.slot, m_res_reg.status};
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_res_reg.last;

endmodule

`default_nettype wire
